### sv/lmrsd_pkg.sv
// package for the led matrix row scan driver core
// request codes, register indexes, scan phase constants and shared structs
// no dependencies
package lmrsd_pkg;

	localparam int unsigned MATRIX_SIDE = 16;
	localparam int unsigned SIDE_W      = $clog2(MATRIX_SIDE);
	localparam int unsigned HOLD_W      = 10;
	localparam int unsigned PHASE_W     = 6;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = HOLD_W;

	typedef logic [SIDE_W-1:0]  side_idx_t;
	typedef logic [HOLD_W-1:0]  hold_t;
	typedef logic [PHASE_W-1:0] phase_t;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_ON     = 2'd1,
		REQ_OFF    = 2'd2,
		REQ_TOGGLE = 2'd3
	} req_type_t;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_COL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 2'd2;

	localparam side_idx_t FIRST_COL_RST  = 4'd5;
	localparam side_idx_t LAST_COL_RST   = 4'd11;
	localparam hold_t     HOLD_TICKS_RST = 10'd100;

	// scan phases within one row
	localparam phase_t PH_BLANK     = 6'd0;
	localparam phase_t PH_BYTE1     = 6'd27;
	localparam phase_t PH_LAST_SEND = 6'd52;
	localparam phase_t PH_LATCH_HI  = 6'd53;
	localparam phase_t PH_LATCH_LO  = 6'd54;
	localparam phase_t PH_ADDR      = 6'd55;
	localparam phase_t PH_UNBLANK   = 6'd56;
	localparam phase_t PH_HOLD      = 6'd57;

	// pin levels, row address in the low bits
	typedef struct packed {
		logic      latch;
		logic      shift_clock;
		logic      serial_data;
		logic      blank;
		side_idx_t row_address;
	} pins_t;

	// sequencer to scene store: snapshot strobe and frame bit select
	typedef struct packed {
		logic      take_snap;
		side_idx_t sel_col;
		side_idx_t sel_row;
	} snap_sel_t;

endpackage

### sv/lmrsd_scene.sv
// scene bit store and per-frame windowed snapshot
// depends on lmrsd_pkg
module lmrsd_scene import lmrsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_go,
	input  req_type_t pix_req,
	input  side_idx_t pix_col,
	input  side_idx_t pix_row,
	input  side_idx_t first_col,
	input  side_idx_t last_col,
	input  snap_sel_t snap_sel,
	output logic      snap_bit
);

	logic [MATRIX_SIDE-1:0] scene_q [MATRIX_SIDE];
	logic [MATRIX_SIDE-1:0] snap_q  [MATRIX_SIDE];
	logic [MATRIX_SIDE-1:0] win_mask;
	logic [MATRIX_SIDE-1:0] pix_mask;

	always_comb begin
		for (int x = 0; x < MATRIX_SIDE; x++) begin
			win_mask[x] = (side_idx_t'(x) >= first_col) && (side_idx_t'(x) <= last_col);
		end
		pix_mask = '0;
		pix_mask[pix_col] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < MATRIX_SIDE; y++) begin
				scene_q[y] <= '1;
				snap_q[y]  <= '0;
			end
		end else begin
			if (pix_go) begin
				case (pix_req)
					REQ_ON:     scene_q[pix_row] <= scene_q[pix_row] & ~pix_mask;
					REQ_OFF:    scene_q[pix_row] <= scene_q[pix_row] | pix_mask;
					REQ_TOGGLE: scene_q[pix_row] <= scene_q[pix_row] ^ pix_mask;
					default:    scene_q[pix_row] <= scene_q[pix_row];
				endcase
			end
			if (snap_sel.take_snap) begin
				for (int y = 0; y < MATRIX_SIDE; y++) begin
					snap_q[y] <= scene_q[y] & win_mask;
				end
			end
		end
	end

	assign snap_bit = snap_q[snap_sel.sel_row][snap_sel.sel_col];

endmodule

### sv/lmrsd_seq.sv
// row scan pin sequencer: blank, shift two bytes, latch, address, unblank, hold
// depends on lmrsd_pkg
module lmrsd_seq import lmrsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tick_go,
	input  hold_t     hold_ticks,
	input  logic      snap_bit,
	output snap_sel_t snap_sel,
	output pins_t     pins
);

	side_idx_t row_q;
	phase_t    phase_q;
	hold_t     hold_q;
	pins_t     pins_q;

	side_idx_t row_d;
	phase_t    phase_d;
	hold_t     hold_d;
	pins_t     pins_d;

	logic      in_hold;
	logic      holding;
	logic      wrap;
	side_idx_t eff_row;
	phase_t    eff_phase;
	logic      second_byte;
	logic [4:0] q_pos;
	logic [4:0] j_pos;
	logic [8:0] j_mul;
	logic [2:0] bit_k;
	logic [4:0] sub_pos;

	always_comb begin
		in_hold   = (phase_q >= PH_HOLD);
		holding   = in_hold && (hold_q != '0);
		wrap      = in_hold && (hold_q == '0);
		eff_row   = wrap ? row_q + side_idx_t'(1) : row_q;
		eff_phase = wrap ? PH_BLANK : phase_q;

		second_byte = (eff_phase >= PH_BYTE1);
		q_pos   = second_byte ? 5'(eff_phase - PH_BYTE1) : 5'(eff_phase - phase_t'(1));
		j_pos   = q_pos - 5'd2;
		// j / 3 for j below 24 as a reciprocal multiply
		j_mul   = 9'(j_pos) * 9'd11;
		bit_k   = j_mul[7:5];
		sub_pos = j_pos - 5'(bit_k) * 5'd3;

		snap_sel.take_snap = 1'b0;
		snap_sel.sel_col   = ~eff_row;
		snap_sel.sel_row   = {~second_byte, ~bit_k};

		row_d   = row_q;
		phase_d = phase_q;
		hold_d  = hold_q;
		pins_d  = pins_q;

		if (tick_go) begin
			if (holding) begin
				hold_d = hold_q - hold_t'(1);
			end else begin
				row_d   = eff_row;
				phase_d = eff_phase + phase_t'(1);
				if (eff_phase == PH_BLANK) begin
					snap_sel.take_snap = (eff_row == '0);
					pins_d.blank = 1'b1;
				end else if (eff_phase <= PH_LAST_SEND) begin
					if (q_pos == 5'd0) begin
						pins_d.shift_clock = 1'b0;
					end else if (q_pos == 5'd1) begin
						pins_d.latch = 1'b0;
					end else if (sub_pos == 5'd0) begin
						pins_d.serial_data = ~snap_bit;
					end else begin
						pins_d.shift_clock = (sub_pos == 5'd1);
					end
				end else if (eff_phase == PH_LATCH_HI) begin
					pins_d.latch = 1'b1;
				end else if (eff_phase == PH_LATCH_LO) begin
					pins_d.latch = 1'b0;
				end else if (eff_phase == PH_ADDR) begin
					pins_d.row_address = eff_row;
				end else begin
					pins_d.blank = 1'b0;
					hold_d = hold_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			phase_q <= PH_BLANK;
			hold_q  <= '0;
			pins_q  <= '0;
		end else begin
			row_q   <= row_d;
			phase_q <= phase_d;
			hold_q  <= hold_d;
			pins_q  <= pins_d;
		end
	end

	assign pins = pins_q;

endmodule

### sv/led_matrix_row_scan_driver_core.sv
// top level of the led matrix row scan driver
// input stage, config registers, scene store and pin sequencer
// depends on lmrsd_pkg, lmrsd_scene, lmrsd_seq
//
// channel   dir  handshake         payload
// s_*       in   tvalid/tready     tdata: req_type, col_x, row_y
// m_*       out  tvalid/tready     tdata: row_address, blank, serial_data, shift_clock, latch
// cfg_*     in   cfg_wr_en         cfg_index, cfg_data (no handshake, no read-back)
//
// one item per clock while the result slot is not stalled; each item passes from accept to result
// through the input register, then one pass of sequencer/scene logic into the pin registers
// the pin registers are the result register: they only change when the result slot is free
// asynchronous active low reset: scene all off, snapshot zero, row 0 phase 0, pins low
// a stalled result holds one more item in the input register, then s_tready drops
module led_matrix_row_scan_driver_core import lmrsd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [1:0] req_type, [5:2] col_x, [9:6] row_y
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [3:0] row_address, [4] blank, [5] serial_data,
	                                         // [6] shift_clock, [7] latch
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// input stage
	logic      valid_s1;
	req_type_t req_s1;
	side_idx_t col_s1;
	side_idx_t row_s1;

	// result slot
	logic      m_valid_q;

	// config registers
	side_idx_t first_col_q;
	side_idx_t last_col_q;
	hold_t     hold_ticks_q;

	logic      advance;
	logic      go;
	logic      s_fire;
	snap_sel_t snap_sel;
	logic      snap_bit;
	pins_t     pins;

	// the result slot is free or being emptied this cycle
	assign advance  = !m_valid_q || m_tready;
	assign go       = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_s1 <= req_type_t'(s_tdata[1:0]);
			col_s1 <= s_tdata[5:2];
			row_s1 <= s_tdata[9:6];
		end
	end

	// config writes, values masked to register width, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_col_q  <= FIRST_COL_RST;
			last_col_q   <= LAST_COL_RST;
			hold_ticks_q <= HOLD_TICKS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FIRST_COL:  first_col_q  <= cfg_data[SIDE_W-1:0];
				CFG_LAST_COL:   last_col_q   <= cfg_data[SIDE_W-1:0];
				CFG_HOLD_TICKS: hold_ticks_q <= cfg_data[HOLD_W-1:0];
				default:        ;
			endcase
		end
	end

	// scene store: pixel requests edit it, the sequencer snapshots it at frame start
	lmrsd_scene u_scene (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_go    (go && (req_s1 != REQ_TICK)),
		.pix_req   (req_s1),
		.pix_col   (col_s1),
		.pix_row   (row_s1),
		.first_col (first_col_q),
		.last_col  (last_col_q),
		.snap_sel  (snap_sel),
		.snap_bit  (snap_bit)
	);

	// pin sequencer: each tick item advances one phase or counts down the hold, pixel items just report the pins
	lmrsd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_go    (go && (req_s1 == REQ_TICK)),
		.hold_ticks (hold_ticks_q),
		.snap_bit   (snap_bit),
		.snap_sel   (snap_sel),
		.pins       (pins)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = pins;

endmodule
